>>> rtl/core/depth_to_false_color_top_assert.svh
// ----------------------------------------------------------------------------
// depth_to_false_color_top assertion macros
// Shared checks for the depth to false color block, clocked on clk and
// quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DEPTH_TO_FALSE_COLOR_TOP_ASSERT_SVH
`define DEPTH_TO_FALSE_COLOR_TOP_ASSERT_SVH

// same-cycle implication
`define D2FC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("d2fc check failed");

// next-cycle implication
`define D2FC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("d2fc check failed");

`endif

>>> rtl/core/d2fc_pkg.sv
// ----------------------------------------------------------------------------
// d2fc_pkg
// Widths, reset values, register indexes and color ramp codes shared by the
// depth to false color pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package d2fc_pkg;

	localparam int NEAR_W     = 16;
	localparam int FAR_W      = 16;
	localparam int BASE_W     = 12;
	localparam int SCALE_W    = 24;
	localparam int DEPTH_W    = 24;
	localparam int CHAN_W     = 8;
	localparam int PVAL_W     = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam int GAMMA_ENTRIES_DEF = 2048;
	localparam int DEPTH_BITS_DEF    = 24;

	// near*far product and the datapath widths that follow from it
	localparam int NF_W   = NEAR_W + FAR_W;
	localparam int TH_W   = FAR_W + 1;
	localparam int PH_W   = SCALE_W + TH_W;
	localparam int A_W    = PH_W + 1;
	localparam int LC_W   = SCALE_W + 1;
	localparam int NUM_W  = A_W + 1;
	// one extra quotient bit flags "quotient beyond any base"
	localparam int DQ_W   = BASE_W + 1;
	localparam int RAMP_W = PVAL_W - CHAN_W;

	localparam logic [NEAR_W-1:0]  NEAR_RST  = NEAR_W'(700);
	localparam logic [FAR_W-1:0]   FAR_RST   = FAR_W'(20000);
	localparam logic [BASE_W-1:0]  BASE_RST  = BASE_W'(1090);
	localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(348000);

	localparam logic [PVAL_W-1:0] GAMMA_GAIN = PVAL_W'(9216);
	localparam logic [CHAN_W-1:0] CHAN_MAX   = CHAN_W'(255);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NEAR  = 2'd0,
		REG_FAR   = 2'd1,
		REG_BASE  = 2'd2,
		REG_SCALE = 2'd3
	} cfg_reg_t;

	localparam logic [RAMP_W-1:0] RAMP_SEG0 = RAMP_W'(0);
	localparam logic [RAMP_W-1:0] RAMP_SEG1 = RAMP_W'(1);
	localparam logic [RAMP_W-1:0] RAMP_SEG2 = RAMP_W'(2);
	localparam logic [RAMP_W-1:0] RAMP_SEG3 = RAMP_W'(3);
	localparam logic [RAMP_W-1:0] RAMP_SEG4 = RAMP_W'(4);
	localparam logic [RAMP_W-1:0] RAMP_SEG5 = RAMP_W'(5);

	typedef struct packed {
		logic [NEAR_W-1:0]  near_mm;
		logic [FAR_W-1:0]   far_mm;
		logic [SCALE_W-1:0] scale;
		logic [NF_W-1:0]    nf_m1;
	} d2fc_cfg_t;

endpackage

>>> rtl/core/d2fc_div.sv
// ----------------------------------------------------------------------------
// d2fc_div
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// The divisor must hold steady while words are in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module d2fc_div import d2fc_pkg::*; #(
	parameter int NUM_W_P  = NUM_W,
	parameter int DEN_W_P  = NF_W,
	parameter int QUOT_W_P = DQ_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  logic [NUM_W_P-1:0]  num,
	input  logic [DEN_W_P-1:0]  den,
	output logic                out_valid,
	output logic [QUOT_W_P-1:0] quot
);

	localparam int SPAN_W = DEN_W_P + QUOT_W_P - 1;
	localparam int RW     = (NUM_W_P > SPAN_W) ? NUM_W_P : SPAN_W;

	logic [RW-1:0]       rem_s  [QUOT_W_P];
	logic [QUOT_W_P-1:0] quot_s [QUOT_W_P];
	logic                vld_s  [QUOT_W_P];

	for (genvar i = 0; i < QUOT_W_P; i++) begin : g_stage
		localparam int B = QUOT_W_P - 1 - i;

		logic [RW-1:0]       r_in;
		logic [RW-1:0]       sub;
		logic [QUOT_W_P-1:0] q_in;
		logic                v_in;
		logic                ge;

		if (i == 0) begin : g_first
			assign r_in = RW'(num);
			assign q_in = '0;
			assign v_in = in_valid;
		end else begin : g_next
			assign r_in = rem_s[i-1];
			assign q_in = quot_s[i-1];
			assign v_in = vld_s[i-1];
		end

		assign sub = RW'(den) << B;
		assign ge  = (r_in >= sub);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i]  <= ge ? (r_in - sub) : r_in;
				quot_s[i] <= q_in | (QUOT_W_P'(ge) << B);
			end
		end
	end

	assign out_valid = vld_s[QUOT_W_P-1];
	assign quot      = quot_s[QUOT_W_P-1];

endmodule

>>> rtl/core/d2fc_front.sv
// ----------------------------------------------------------------------------
// d2fc_front
// Five-stage front end: scaled inverse depth numerator
// ceil(scale*t/2^DB) + near*far - 1, with t = far*(2^DB - D) + near*D.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module d2fc_front import d2fc_pkg::*; #(
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic [DEPTH_W-1:0] depth_value,
	input  d2fc_cfg_t          cfg,
	output logic               out_valid,
	output logic [NUM_W-1:0]   num
);

	localparam int TW   = DEPTH_BITS + TH_W;
	localparam int PN_W = DEPTH_BITS + NEAR_W;
	localparam int PL_W = SCALE_W + DEPTH_BITS;

	logic [DEPTH_BITS-1:0] d;
	logic [DEPTH_BITS:0]   d_inv;
	logic [PL_W:0]         pl_round;

	logic [TW-1:0]    pf_s1;
	logic [PN_W-1:0]  pn_s1;
	logic [TW-1:0]    t_s2;
	logic [PH_W-1:0]  ph_s3;
	logic [PL_W-1:0]  pl_s3;
	logic [A_W-1:0]   a_s4;
	logic [LC_W-1:0]  lc_s4;
	logic [NUM_W-1:0] num_s5;
	logic             v_s1, v_s2, v_s3, v_s4, v_s5;

	// only the low DEPTH_BITS of the word count
	assign d        = DEPTH_BITS'(depth_value);
	assign d_inv    = {1'b1, {DEPTH_BITS{1'b0}}} - {1'b0, d};
	assign pl_round = (PL_W + 1)'(pl_s3) + (PL_W + 1)'({DEPTH_BITS{1'b1}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pf_s1  <= TW'(cfg.far_mm) * TW'(d_inv);
			pn_s1  <= PN_W'(cfg.near_mm) * PN_W'(d);
			t_s2   <= pf_s1 + TW'(pn_s1);
			ph_s3  <= PH_W'(cfg.scale) * PH_W'(t_s2[DEPTH_BITS +: TH_W]);
			pl_s3  <= PL_W'(cfg.scale) * PL_W'(t_s2[DEPTH_BITS-1:0]);
			a_s4   <= A_W'(ph_s3) + A_W'(cfg.nf_m1);
			lc_s4  <= pl_round[DEPTH_BITS +: LC_W];
			num_s5 <= NUM_W'(a_s4) + NUM_W'(lc_s4);
		end
	end

	assign out_valid = v_s5;
	assign num       = num_s5;

endmodule

>>> rtl/core/d2fc_gamma.sv
// ----------------------------------------------------------------------------
// d2fc_gamma
// Disparity index clamp followed by the cubic gamma curve
// pval = floor(9216*kd^3 / GAMMA_ENTRIES^3), computed rather than stored.
// Users keep GAMMA_ENTRIES a power of two, unchecked here; division is a shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module d2fc_gamma import d2fc_pkg::*; #(
	parameter int GAMMA_ENTRIES = GAMMA_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  logic [DQ_W-1:0]   quot,
	input  logic [BASE_W-1:0] base,
	output logic              out_valid,
	output logic [PVAL_W-1:0] pval
);

	localparam int KW   = $clog2(GAMMA_ENTRIES);
	localparam int K2_W = 2 * KW;
	localparam int K3_W = 3 * KW;
	localparam int GN_W = K3_W + PVAL_W;

	localparam logic [KW-1:0]     KD_MAX   = KW'(GAMMA_ENTRIES - 1);
	localparam logic [BASE_W-1:0] KD_MAX_B = BASE_W'(GAMMA_ENTRIES - 1);

	logic [BASE_W-1:0] q_lo;
	logic [BASE_W-1:0] diff;
	logic              kd_zero;
	logic [KW-1:0]     kd_next;

	logic [KW-1:0]   kd_s1, kd_s2;
	logic [K2_W-1:0] kd2_s2;
	logic [K3_W-1:0] kd3_s3;
	logic [GN_W-1:0] gnum_s4;
	logic            v_s1, v_s2, v_s3, v_s4;

	// top quotient bit set: scaled inverse depth beyond any base
	assign q_lo    = quot[BASE_W-1:0];
	assign kd_zero = quot[DQ_W-1] || (q_lo >= base);
	assign diff    = base - q_lo;
	assign kd_next = kd_zero ? '0 : ((diff > KD_MAX_B) ? KD_MAX : KW'(diff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kd_s1   <= kd_next;
			kd_s2   <= kd_s1;
			kd2_s2  <= K2_W'(kd_s1) * K2_W'(kd_s1);
			kd3_s3  <= K3_W'(kd2_s2) * K3_W'(kd_s2);
			gnum_s4 <= GN_W'(kd3_s3) * GN_W'(GAMMA_GAIN);
		end
	end

	// divide by GAMMA_ENTRIES^3
	assign out_valid = v_s4;
	assign pval      = gnum_s4[K3_W +: PVAL_W];

endmodule

>>> rtl/core/d2fc_color.sv
// ----------------------------------------------------------------------------
// d2fc_color
// Ramp select and shading; also the output register of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module d2fc_color import d2fc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  logic [PVAL_W-1:0] pval,
	output logic              out_valid,
	output logic [CHAN_W-1:0] chan0,
	output logic [CHAN_W-1:0] chan1,
	output logic [CHAN_W-1:0] chan2
);

	logic [RAMP_W-1:0] ramp;
	logic [CHAN_W-1:0] lb;
	logic [CHAN_W-1:0] c0, c1, c2;
	logic              v_q;
	logic [CHAN_W-1:0] c0_q, c1_q, c2_q;

	assign ramp = pval[PVAL_W-1:CHAN_W];
	assign lb   = pval[CHAN_W-1:0];

	always_comb begin
		c0 = '0;
		c1 = '0;
		c2 = '0;
		case (ramp)
			RAMP_SEG0: begin
				c2 = CHAN_MAX;
				c1 = CHAN_MAX - lb;
				c0 = CHAN_MAX - lb;
			end
			RAMP_SEG1: begin
				c2 = CHAN_MAX;
				c1 = lb;
			end
			RAMP_SEG2: begin
				c2 = CHAN_MAX - lb;
				c1 = CHAN_MAX;
			end
			RAMP_SEG3: begin
				c1 = CHAN_MAX;
				c0 = lb;
			end
			RAMP_SEG4: begin
				c1 = CHAN_MAX - lb;
				c0 = CHAN_MAX;
			end
			RAMP_SEG5: begin
				c0 = CHAN_MAX - lb;
			end
			default: begin
				c0 = '0;
				c1 = '0;
				c2 = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c0_q <= c0;
			c1_q <= c1;
			c2_q <= c2;
		end
	end

	assign out_valid = v_q;
	assign chan0     = c0_q;
	assign chan1     = c1_q;
	assign chan2     = c2_q;

endmodule

>>> rtl/core/depth_to_false_color_top.sv
// ----------------------------------------------------------------------------
// depth_to_false_color_top
// Turns one normalized depth word per clock into one three-byte false color
// pixel while the output is not stalled. Throughput is one pixel per clock
// under the same condition. The pipeline has 5 front end stages, 13 stages of
// the disparity divider at one quotient bit each, 4 index and cube stages and
// 1 output register. GAMMA_ENTRIES must be a power of two. The whole pipeline
// holds while an output word is stalled, so depth_stall is pixel_valid and
// pixel_stall together. Register writes belong in idle time; after the last
// write the near*far product is registered, then near*far - 1 from it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "depth_to_false_color_top_assert.svh"

module depth_to_false_color_top import d2fc_pkg::*; #(
	parameter int GAMMA_ENTRIES = GAMMA_ENTRIES_DEF,
	parameter int DEPTH_BITS    = DEPTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  depth_valid,
	output logic                  depth_stall,
	input  logic [DEPTH_W-1:0]    depth_value,
	output logic                  pixel_valid,
	input  logic                  pixel_stall,
	output logic [CHAN_W-1:0]     chan0,
	output logic [CHAN_W-1:0]     chan1,
	output logic [CHAN_W-1:0]     chan2
);

	logic [NEAR_W-1:0]  near_q;
	logic [FAR_W-1:0]   far_q;
	logic [BASE_W-1:0]  base_q;
	logic [SCALE_W-1:0] scale_q;
	logic [NF_W-1:0]    nf_q;
	logic [NF_W-1:0]    nf_m1_q;

	d2fc_cfg_t         cfg;
	logic              adv;
	logic              num_valid;
	logic [NUM_W-1:0]  num;
	logic              dq_valid;
	logic [DQ_W-1:0]   dq;
	logic              pval_valid;
	logic [PVAL_W-1:0] pval;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q  <= NEAR_RST;
			far_q   <= FAR_RST;
			base_q  <= BASE_RST;
			scale_q <= SCALE_RST;
			nf_q    <= NF_W'(NEAR_RST) * NF_W'(FAR_RST);
			nf_m1_q <= NF_W'(NEAR_RST) * NF_W'(FAR_RST) - NF_W'(1);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_NEAR:  near_q  <= cfg_data[NEAR_W-1:0];
					REG_FAR:   far_q   <= cfg_data[FAR_W-1:0];
					REG_BASE:  base_q  <= cfg_data[BASE_W-1:0];
					REG_SCALE: scale_q <= cfg_data[SCALE_W-1:0];
					default: ;
				endcase
			end
			nf_q    <= NF_W'(near_q) * NF_W'(far_q);
			// wraps when a plane is zero; the divider then flags overflow
			nf_m1_q <= nf_q - NF_W'(1);
		end
	end

	assign cfg.near_mm = near_q;
	assign cfg.far_mm  = far_q;
	assign cfg.scale   = scale_q;
	assign cfg.nf_m1   = nf_m1_q;

	assign depth_stall = pixel_valid & pixel_stall;
	assign adv         = ~depth_stall;

	d2fc_front #(
		.DEPTH_BITS (DEPTH_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (depth_valid),
		.depth_value (depth_value),
		.cfg         (cfg),
		.out_valid   (num_valid),
		.num         (num)
	);

	// x = ceil(c / (near*far)); only whether x reaches 2^BASE_W matters above
	d2fc_div #(
		.NUM_W_P  (NUM_W),
		.DEN_W_P  (NF_W),
		.QUOT_W_P (DQ_W)
	) u_ddiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (num_valid),
		.num       (num),
		.den       (nf_q),
		.out_valid (dq_valid),
		.quot      (dq)
	);

	d2fc_gamma #(
		.GAMMA_ENTRIES (GAMMA_ENTRIES)
	) u_gamma (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (dq_valid),
		.quot      (dq),
		.base      (base_q),
		.out_valid (pval_valid),
		.pval      (pval)
	);

	d2fc_color u_color (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (pval_valid),
		.pval      (pval),
		.out_valid (pixel_valid),
		.chan0     (chan0),
		.chan1     (chan1),
		.chan2     (chan2)
	);

	`D2FC_ASSERT_NEXT(a_nf_tracks_planes, !cfg_we, nf_q == NF_W'(near_q) * NF_W'(far_q))
	`D2FC_ASSERT_NEXT(a_nf_m1_tracks, !cfg_we && !$past(cfg_we), nf_m1_q == nf_q - NF_W'(1))
	`D2FC_ASSERT_IMPL(a_pval_in_range, pval_valid, pval < GAMMA_GAIN)

endmodule
